// ===== rtl/core/mfsp_pkg.sv =====
// shared types and constants for the midi file stream parser
package mfsp_pkg;

    // parser phase
    typedef enum logic [3:0] {
        PH_HMAGIC = 4'd0,
        PH_HLEN   = 4'd1,
        PH_HDATA  = 4'd2,
        PH_TMAGIC = 4'd3,
        PH_TLEN   = 4'd4,
        PH_DELTA  = 4'd5,
        PH_STATUS = 4'd6,
        PH_PARAM1 = 4'd7,
        PH_PARAM2 = 4'd8,
        PH_MTYPE  = 4'd9,
        PH_MLEN   = 4'd10,
        PH_MDATA  = 4'd11,
        PH_XLEN   = 4'd12,
        PH_XDATA  = 4'd13,
        PH_DONE   = 4'd14,
        PH_ERR    = 4'd15
    } phase_t;

    // result kind codes
    typedef enum logic [2:0] {
        KIND_HEADER    = 3'd0,
        KIND_CHANNEL   = 3'd1,
        KIND_META_HDR  = 3'd2,
        KIND_META_DATA = 3'd3,
        KIND_SYSEX     = 3'd4,
        KIND_ERROR     = 3'd5
    } kind_t;

    // one result
    typedef struct packed {
        kind_t       kind;
        logic [31:0] delta;
        logic [7:0]  event_type;
        logic [3:0]  channel;
        logic [7:0]  param1;
        logic [7:0]  param2;
        logic [7:0]  meta_type;
        logic [31:0] length;
        logic [15:0] format;
        logic [15:0] track_count;
        logic        smpte_division;
        logic [14:0] time_division;
    } result_t;

    localparam logic [7:0] HDR_MAGIC [4] = '{8'h4D, 8'h54, 8'h68, 8'h64};
    localparam logic [7:0] TRK_MAGIC [4] = '{8'h4D, 8'h54, 8'h72, 8'h6B};

    localparam logic [31:0] HDR_LENGTH        = 32'd6;
    localparam logic [2:0]  MAGIC_BYTES       = 3'd4;
    localparam logic [2:0]  LEN_BYTES         = 3'd4;
    localparam logic [2:0]  HDR_DATA_BYTES    = 3'd6;
    localparam logic [7:0]  STATUS_META       = 8'hFF;
    localparam logic [7:0]  STATUS_SYSEX      = 8'hF0;
    localparam logic [7:0]  STATUS_SYSEX_ESC  = 8'hF7;
    localparam logic [3:0]  TYPE_SYSTEM       = 4'hF;
    localparam logic [3:0]  TYPE_PROG_CHANGE  = 4'hC;
    localparam logic [3:0]  TYPE_CHAN_PRESS   = 4'hD;
    localparam logic [7:0]  META_END_OF_TRACK = 8'h2F;
    localparam logic [7:0]  META_EVENT_TYPE   = 8'hFF;
    localparam logic [3:0]  META_CHANNEL      = 4'hF;

endpackage

// ===== rtl/core/midi_file_stream_parser_core.sv =====
// midi file stream parser: byte-wide parser with a registered result stage
//
// the parser takes one raw byte of a standard midi file per request and gives at most
// one result per byte. every request is handled at the edge that accepts it: the phase
// machine and its counters update at that edge, and any result lands in the output
// register at that same edge, so a new byte can be taken every clock for a
// sustained rate of one byte per cycle. the only thing that holds the input back is a
// result still waiting in the output register while the consumer stalls. a request
// with restart set returns the parser to the file header and gives no result. after
// a bad magic, bad header length, undefined status or a data byte without running
// status, one error result is given and all later bytes are dropped until restart.
// once the header's track count is used up, bytes are dropped until restart as well.
module midi_file_stream_parser_core
    import mfsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // byte request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        restart,
    input  logic [7:0]  in_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [31:0] delta,
    output logic [7:0]  event_type,
    output logic [3:0]  channel,
    output logic [7:0]  param1,
    output logic [7:0]  param2,
    output logic [7:0]  meta_type,
    output logic [31:0] length,
    output logic [15:0] format,
    output logic [15:0] track_count,
    output logic        smpte_division,
    output logic [14:0] time_division
);

    // parser state
    phase_t      phase_reg, phase_next;
    logic [2:0]  byte_count_reg, byte_count_next;
    logic [31:0] accumulator_reg, accumulator_next;
    logic [7:0]  running_status_reg, running_status_next;
    logic [31:0] event_delta_reg, event_delta_next;
    logic [7:0]  event_status_reg, event_status_next;
    logic [7:0]  first_data_reg, first_data_next;
    logic [7:0]  meta_kind_reg, meta_kind_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [15:0] tracks_left_reg, tracks_left_next;
    logic [47:0] header_words_reg, header_words_next;

    // output stage
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     result_next;
    logic        emit;

    logic        in_fire;
    logic        out_fire;

    // shared datapath pieces
    logic [31:0] acc_vl;         // accumulator with next 7-bit group shifted in
    logic        vl_last;        // last byte of a variable-length value
    logic [31:0] acc_len;        // accumulator with next full byte shifted in
    logic [47:0] hdr_shift;
    logic [31:0] bytes_dec;
    logic [15:0] tracks_dec;
    logic [2:0]  bc_inc;
    logic        status_one_data;
    logic        run_one_data;
    logic        meta_ends_track;
    logic        last_track;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;

    assign acc_vl          = {accumulator_reg[24:0], in_byte[6:0]};
    assign vl_last         = !in_byte[7];
    assign acc_len         = {accumulator_reg[23:0], in_byte};
    assign hdr_shift       = {header_words_reg[39:0], in_byte};
    assign bytes_dec       = bytes_left_reg - 32'd1;
    assign tracks_dec      = tracks_left_reg - 16'd1;
    assign bc_inc          = byte_count_reg + 3'd1;
    assign status_one_data = (event_status_reg[7:4] == TYPE_PROG_CHANGE) ||
                             (event_status_reg[7:4] == TYPE_CHAN_PRESS);
    assign run_one_data    = (running_status_reg[7:4] == TYPE_PROG_CHANGE) ||
                             (running_status_reg[7:4] == TYPE_CHAN_PRESS);
    assign meta_ends_track = (meta_kind_reg == META_END_OF_TRACK);
    assign last_track      = (tracks_dec == 16'd0);

    // next state and result for the byte at the input
    always_comb
    begin
        phase_next          = phase_reg;
        byte_count_next     = byte_count_reg;
        accumulator_next    = accumulator_reg;
        running_status_next = running_status_reg;
        event_delta_next    = event_delta_reg;
        event_status_next   = event_status_reg;
        first_data_next     = first_data_reg;
        meta_kind_next      = meta_kind_reg;
        bytes_left_next     = bytes_left_reg;
        tracks_left_next    = tracks_left_reg;
        header_words_next   = header_words_reg;
        result_next         = '0;
        emit                = 1'b0;

        if (restart)
        begin
            phase_next          = PH_HMAGIC;
            byte_count_next     = '0;
            accumulator_next    = '0;
            running_status_next = '0;
            event_delta_next    = '0;
            event_status_next   = '0;
            first_data_next     = '0;
            meta_kind_next      = '0;
            bytes_left_next     = '0;
            tracks_left_next    = '0;
            header_words_next   = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_HMAGIC:
                begin
                    if (in_byte != HDR_MAGIC[byte_count_reg[1:0]])
                    begin
                        phase_next       = PH_ERR;
                        result_next.kind = KIND_ERROR;
                        emit             = 1'b1;
                    end
                    else if (bc_inc == MAGIC_BYTES)
                    begin
                        byte_count_next  = '0;
                        accumulator_next = '0;
                        phase_next       = PH_HLEN;
                    end
                    else
                    begin
                        byte_count_next = bc_inc;
                    end
                end
                PH_HLEN:
                begin
                    accumulator_next = acc_len;
                    byte_count_next  = bc_inc;
                    if (bc_inc == LEN_BYTES)
                    begin
                        byte_count_next = '0;
                        if (acc_len != HDR_LENGTH)
                        begin
                            phase_next       = PH_ERR;
                            result_next.kind = KIND_ERROR;
                            emit             = 1'b1;
                        end
                        else
                        begin
                            header_words_next = '0;
                            phase_next        = PH_HDATA;
                        end
                    end
                end
                PH_HDATA:
                begin
                    header_words_next = hdr_shift;
                    byte_count_next   = bc_inc;
                    if (bc_inc == HDR_DATA_BYTES)
                    begin
                        byte_count_next            = '0;
                        result_next.kind           = KIND_HEADER;
                        result_next.format         = hdr_shift[47:32];
                        result_next.track_count    = hdr_shift[31:16];
                        result_next.smpte_division = hdr_shift[15];
                        result_next.time_division  = hdr_shift[14:0];
                        emit                       = 1'b1;
                        tracks_left_next           = hdr_shift[31:16];
                        phase_next = (hdr_shift[31:16] == 16'd0) ? PH_DONE : PH_TMAGIC;
                    end
                end
                PH_TMAGIC:
                begin
                    if (in_byte != TRK_MAGIC[byte_count_reg[1:0]])
                    begin
                        phase_next       = PH_ERR;
                        result_next.kind = KIND_ERROR;
                        emit             = 1'b1;
                    end
                    else if (bc_inc == MAGIC_BYTES)
                    begin
                        byte_count_next = '0;
                        phase_next      = PH_TLEN;
                    end
                    else
                    begin
                        byte_count_next = bc_inc;
                    end
                end
                PH_TLEN:
                begin
                    // chunk length is not needed, the events carry their own framing
                    byte_count_next = bc_inc;
                    if (bc_inc == LEN_BYTES)
                    begin
                        byte_count_next     = '0;
                        running_status_next = '0;
                        accumulator_next    = '0;
                        phase_next          = PH_DELTA;
                    end
                end
                PH_DELTA:
                begin
                    accumulator_next = acc_vl;
                    if (vl_last)
                    begin
                        event_delta_next = acc_vl;
                        phase_next       = PH_STATUS;
                    end
                end
                PH_STATUS:
                begin
                    if (!in_byte[7])
                    begin
                        // data byte: running status applies
                        if (running_status_reg == 8'd0)
                        begin
                            phase_next       = PH_ERR;
                            result_next.kind = KIND_ERROR;
                            emit             = 1'b1;
                        end
                        else
                        begin
                            event_status_next = running_status_reg;
                            first_data_next   = in_byte;
                            if (run_one_data)
                            begin
                                result_next.kind       = KIND_CHANNEL;
                                result_next.delta      = event_delta_reg;
                                result_next.event_type = {running_status_reg[7:4], 4'h0};
                                result_next.channel    = running_status_reg[3:0];
                                result_next.param1     = in_byte;
                                emit                   = 1'b1;
                                accumulator_next       = '0;
                                phase_next             = PH_DELTA;
                            end
                            else
                            begin
                                phase_next = PH_PARAM2;
                            end
                        end
                    end
                    else if (in_byte[7:4] != TYPE_SYSTEM)
                    begin
                        event_status_next   = in_byte;
                        running_status_next = in_byte;
                        phase_next          = PH_PARAM1;
                    end
                    else if (in_byte == STATUS_META)
                    begin
                        event_status_next = in_byte;
                        phase_next        = PH_MTYPE;
                    end
                    else if ((in_byte == STATUS_SYSEX) || (in_byte == STATUS_SYSEX_ESC))
                    begin
                        event_status_next = in_byte;
                        accumulator_next  = '0;
                        phase_next        = PH_XLEN;
                    end
                    else
                    begin
                        // undefined system status
                        phase_next       = PH_ERR;
                        result_next.kind = KIND_ERROR;
                        emit             = 1'b1;
                    end
                end
                PH_PARAM1:
                begin
                    first_data_next = in_byte;
                    if (status_one_data)
                    begin
                        result_next.kind       = KIND_CHANNEL;
                        result_next.delta      = event_delta_reg;
                        result_next.event_type = {event_status_reg[7:4], 4'h0};
                        result_next.channel    = event_status_reg[3:0];
                        result_next.param1     = in_byte;
                        emit                   = 1'b1;
                        accumulator_next       = '0;
                        phase_next             = PH_DELTA;
                    end
                    else
                    begin
                        phase_next = PH_PARAM2;
                    end
                end
                PH_PARAM2:
                begin
                    result_next.kind       = KIND_CHANNEL;
                    result_next.delta      = event_delta_reg;
                    result_next.event_type = {event_status_reg[7:4], 4'h0};
                    result_next.channel    = event_status_reg[3:0];
                    result_next.param1     = first_data_reg;
                    result_next.param2     = in_byte;
                    emit                   = 1'b1;
                    accumulator_next       = '0;
                    phase_next             = PH_DELTA;
                end
                PH_MTYPE:
                begin
                    meta_kind_next   = in_byte;
                    accumulator_next = '0;
                    phase_next       = PH_MLEN;
                end
                PH_MLEN:
                begin
                    accumulator_next = acc_vl;
                    if (vl_last)
                    begin
                        bytes_left_next        = acc_vl;
                        result_next.kind       = KIND_META_HDR;
                        result_next.delta      = event_delta_reg;
                        result_next.event_type = META_EVENT_TYPE;
                        result_next.channel    = META_CHANNEL;
                        result_next.meta_type  = meta_kind_reg;
                        result_next.length     = acc_vl;
                        emit                   = 1'b1;
                        if (acc_vl != 32'd0)
                        begin
                            phase_next = PH_MDATA;
                        end
                        else if (meta_ends_track)
                        begin
                            tracks_left_next = tracks_dec;
                            byte_count_next  = '0;
                            phase_next       = last_track ? PH_DONE : PH_TMAGIC;
                        end
                        else
                        begin
                            accumulator_next = '0;
                            phase_next       = PH_DELTA;
                        end
                    end
                end
                PH_MDATA:
                begin
                    result_next.kind       = KIND_META_DATA;
                    result_next.delta      = event_delta_reg;
                    result_next.event_type = META_EVENT_TYPE;
                    result_next.channel    = META_CHANNEL;
                    result_next.param1     = in_byte;
                    result_next.meta_type  = meta_kind_reg;
                    result_next.length     = accumulator_reg;
                    emit                   = 1'b1;
                    bytes_left_next        = bytes_dec;
                    if (bytes_dec == 32'd0)
                    begin
                        if (meta_ends_track)
                        begin
                            tracks_left_next = tracks_dec;
                            byte_count_next  = '0;
                            phase_next       = last_track ? PH_DONE : PH_TMAGIC;
                        end
                        else
                        begin
                            accumulator_next = '0;
                            phase_next       = PH_DELTA;
                        end
                    end
                end
                PH_XLEN:
                begin
                    accumulator_next = acc_vl;
                    if (vl_last)
                    begin
                        bytes_left_next = acc_vl;
                        if (acc_vl == 32'd0)
                        begin
                            result_next.kind       = KIND_SYSEX;
                            result_next.delta      = event_delta_reg;
                            result_next.event_type = {event_status_reg[7:4], 4'h0};
                            result_next.channel    = event_status_reg[3:0];
                            result_next.length     = acc_vl;
                            emit                   = 1'b1;
                            accumulator_next       = '0;
                            phase_next             = PH_DELTA;
                        end
                        else
                        begin
                            phase_next = PH_XDATA;
                        end
                    end
                end
                PH_XDATA:
                begin
                    // payload is dropped, only the count matters
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 32'd0)
                    begin
                        result_next.kind       = KIND_SYSEX;
                        result_next.delta      = event_delta_reg;
                        result_next.event_type = {event_status_reg[7:4], 4'h0};
                        result_next.channel    = event_status_reg[3:0];
                        result_next.length     = accumulator_reg;
                        emit                   = 1'b1;
                        accumulator_next       = '0;
                        phase_next             = PH_DELTA;
                    end
                end
                PH_DONE, PH_ERR:
                begin
                    // bytes are dropped until restart
                end
                default:
                begin
                end
            endcase
        end
    end

    // state register, only moves on an accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HMAGIC;
            byte_count_reg     <= '0;
            accumulator_reg    <= '0;
            running_status_reg <= '0;
            event_delta_reg    <= '0;
            event_status_reg   <= '0;
            first_data_reg     <= '0;
            meta_kind_reg      <= '0;
            bytes_left_reg     <= '0;
            tracks_left_reg    <= '0;
            header_words_reg   <= '0;
        end
        else if (in_fire)
        begin
            phase_reg          <= phase_next;
            byte_count_reg     <= byte_count_next;
            accumulator_reg    <= accumulator_next;
            running_status_reg <= running_status_next;
            event_delta_reg    <= event_delta_next;
            event_status_reg   <= event_status_next;
            first_data_reg     <= first_data_next;
            meta_kind_reg      <= meta_kind_next;
            bytes_left_reg     <= bytes_left_next;
            tracks_left_reg    <= tracks_left_next;
            header_words_reg   <= header_words_next;
        end
    end

    // output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= emit;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload, loaded only with a fresh result
    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = result_reg.kind;
    assign delta          = result_reg.delta;
    assign event_type     = result_reg.event_type;
    assign channel        = result_reg.channel;
    assign param1         = result_reg.param1;
    assign param2         = result_reg.param2;
    assign meta_type      = result_reg.meta_type;
    assign length         = result_reg.length;
    assign format         = result_reg.format;
    assign track_count    = result_reg.track_count;
    assign smpte_division = result_reg.smpte_division;
    assign time_division  = result_reg.time_division;

    // a latched error drops every byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !restart && (phase_reg == PH_ERR)) |=> !out_valid_reg)
        else $error("result produced while error latched");

    // restart returns to the file header without a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && restart) |=> (!out_valid_reg && (phase_reg == PH_HMAGIC)))
        else $error("restart did not clear the parser");

    // a pending error result always goes with the error phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.kind == KIND_ERROR)) |-> (phase_reg == PH_ERR))
        else $error("error result without latched error");

    // payload phases never sit on an exhausted count
    assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_MDATA) || (phase_reg == PH_XDATA)) |-> (bytes_left_reg != 32'd0))
        else $error("payload phase with zero bytes left");

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for the midi file stream parser core
`timescale 1ns / 100ps

module tb;
    import mfsp_pkg::*;

    // one request on the byte channel
    typedef struct packed {
        logic       rs;
        logic [7:0] b;
    } byte_req_t;

    // predicts parser results byte by byte and matches them against the block
    class smf_event_board;
        result_t     awaited_events[$];
        int          errors;
        int          kind_seen[8];
        phase_t      ph;
        logic [3:0]  cnt;
        logic [31:0] acc;
        logic [31:0] ev_delta;
        logic [31:0] remain;
        logic [7:0]  run_st;
        logic [7:0]  ev_st;
        logic [7:0]  data1;
        logic [7:0]  mkind;
        logic [15:0] trk_left;
        logic [47:0] hdr;

        function new();
            errors = 0;
            foreach (kind_seen[i])
                kind_seen[i] = 0;
            clear();
        endfunction

        function void clear();
            ph       = PH_HMAGIC;
            cnt      = '0;
            acc      = '0;
            ev_delta = '0;
            remain   = '0;
            run_st   = '0;
            ev_st    = '0;
            data1    = '0;
            mkind    = '0;
            trk_left = '0;
            hdr      = '0;
        endfunction

        function bit fault(inout result_t r);
            ph     = PH_ERR;
            r.kind = KIND_ERROR;
            return 1'b1;
        endfunction

        function void start_delta();
            ph  = PH_DELTA;
            acc = '0;
        endfunction

        // end-of-track meta moves on to the next track or to done
        function void end_meta();
            if (mkind == META_END_OF_TRACK)
            begin
                trk_left = trk_left - 16'd1;
                cnt      = '0;
                ph       = (trk_left == 0) ? PH_DONE : PH_TMAGIC;
            end
            else
                start_delta();
        endfunction

        function bit vl_step(logic [7:0] b);
            acc = {acc[24:0], b[6:0]};
            return !b[7];
        endfunction

        function bit one_data(logic [7:0] st);
            return st[7:4] == TYPE_PROG_CHANGE || st[7:4] == TYPE_CHAN_PRESS;
        endfunction

        function bit chan_event(inout result_t r, input logic [7:0] p2);
            r.kind       = KIND_CHANNEL;
            r.delta      = ev_delta;
            r.event_type = {ev_st[7:4], 4'h0};
            r.channel    = ev_st[3:0];
            r.param1     = data1;
            r.param2     = p2;
            start_delta();
            return 1'b1;
        endfunction

        function bit sysex_done(inout result_t r);
            r.kind       = KIND_SYSEX;
            r.delta      = ev_delta;
            r.event_type = {ev_st[7:4], 4'h0};
            r.channel    = ev_st[3:0];
            r.length     = acc;
            start_delta();
            return 1'b1;
        endfunction

        // advance the parser by one byte, returns 1 when a result is due
        function bit parse_byte(bit rs, logic [7:0] b, output result_t r);
            bit hit;
            r   = '0;
            hit = 1'b0;
            if (rs)
            begin
                clear();
                return 1'b0;
            end
            case (ph)
                PH_HMAGIC:
                begin
                    if (b != HDR_MAGIC[cnt[1:0]])
                        hit = fault(r);
                    else
                    begin
                        cnt = cnt + 4'd1;
                        if (cnt == MAGIC_BYTES)
                        begin
                            cnt = '0;
                            acc = '0;
                            ph  = PH_HLEN;
                        end
                    end
                end
                PH_HLEN:
                begin
                    acc = {acc[23:0], b};
                    cnt = cnt + 4'd1;
                    if (cnt == LEN_BYTES)
                    begin
                        cnt = '0;
                        if (acc != HDR_LENGTH)
                            hit = fault(r);
                        else
                        begin
                            hdr = '0;
                            ph  = PH_HDATA;
                        end
                    end
                end
                PH_HDATA:
                begin
                    hdr = {hdr[39:0], b};
                    cnt = cnt + 4'd1;
                    if (cnt == HDR_DATA_BYTES)
                    begin
                        cnt              = '0;
                        r.kind           = KIND_HEADER;
                        r.format         = hdr[47:32];
                        r.track_count    = hdr[31:16];
                        r.smpte_division = hdr[15];
                        r.time_division  = hdr[14:0];
                        hit              = 1'b1;
                        trk_left         = hdr[31:16];
                        ph               = (trk_left == 0) ? PH_DONE : PH_TMAGIC;
                    end
                end
                PH_TMAGIC:
                begin
                    if (b != TRK_MAGIC[cnt[1:0]])
                        hit = fault(r);
                    else
                    begin
                        cnt = cnt + 4'd1;
                        if (cnt == MAGIC_BYTES)
                        begin
                            cnt = '0;
                            ph  = PH_TLEN;
                        end
                    end
                end
                PH_TLEN:
                begin
                    cnt = cnt + 4'd1;
                    if (cnt == LEN_BYTES)
                    begin
                        cnt    = '0;
                        run_st = '0;
                        start_delta();
                    end
                end
                PH_DELTA:
                begin
                    if (vl_step(b))
                    begin
                        ev_delta = acc;
                        ph       = PH_STATUS;
                    end
                end
                PH_STATUS:
                begin
                    if (!b[7])
                    begin
                        if (run_st == 0)
                            hit = fault(r);
                        else
                        begin
                            ev_st = run_st;
                            data1 = b;
                            if (one_data(ev_st))
                                hit = chan_event(r, 8'h00);
                            else
                                ph = PH_PARAM2;
                        end
                    end
                    else if (b[7:4] != TYPE_SYSTEM)
                    begin
                        ev_st  = b;
                        run_st = b;
                        ph     = PH_PARAM1;
                    end
                    else if (b == STATUS_META)
                    begin
                        ev_st = b;
                        ph    = PH_MTYPE;
                    end
                    else if (b == STATUS_SYSEX || b == STATUS_SYSEX_ESC)
                    begin
                        ev_st = b;
                        acc   = '0;
                        ph    = PH_XLEN;
                    end
                    else
                        hit = fault(r);
                end
                PH_PARAM1:
                begin
                    data1 = b;
                    if (one_data(ev_st))
                        hit = chan_event(r, 8'h00);
                    else
                        ph = PH_PARAM2;
                end
                PH_PARAM2:
                    hit = chan_event(r, b);
                PH_MTYPE:
                begin
                    mkind = b;
                    acc   = '0;
                    ph    = PH_MLEN;
                end
                PH_MLEN:
                begin
                    if (vl_step(b))
                    begin
                        remain       = acc;
                        r.kind       = KIND_META_HDR;
                        r.delta      = ev_delta;
                        r.event_type = META_EVENT_TYPE;
                        r.channel    = META_CHANNEL;
                        r.meta_type  = mkind;
                        r.length     = acc;
                        hit          = 1'b1;
                        if (remain == 0)
                            end_meta();
                        else
                            ph = PH_MDATA;
                    end
                end
                PH_MDATA:
                begin
                    r.kind       = KIND_META_DATA;
                    r.delta      = ev_delta;
                    r.event_type = META_EVENT_TYPE;
                    r.channel    = META_CHANNEL;
                    r.param1     = b;
                    r.meta_type  = mkind;
                    r.length     = acc;
                    hit          = 1'b1;
                    remain       = remain - 32'd1;
                    if (remain == 0)
                        end_meta();
                end
                PH_XLEN:
                begin
                    if (vl_step(b))
                    begin
                        remain = acc;
                        if (remain == 0)
                            hit = sysex_done(r);
                        else
                            ph = PH_XDATA;
                    end
                end
                PH_XDATA:
                begin
                    remain = remain - 32'd1;
                    if (remain == 0)
                        hit = sysex_done(r);
                end
                default:
                    ;
            endcase
            return hit;
        endfunction

        function void note_request(bit rs, logic [7:0] b);
            result_t r;
            if (parse_byte(rs, b, r))
                awaited_events.push_back(r);
        endfunction

        function void cmp(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s expected %0h actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_event(result_t got);
            result_t want;
            if (awaited_events.size() == 0)
            begin
                $error("unexpected result of kind %0d", got.kind);
                errors++;
                return;
            end
            want = awaited_events.pop_front();
            kind_seen[want.kind]++;
            cmp("kind", want.kind, got.kind);
            cmp("delta", want.delta, got.delta);
            cmp("event_type", want.event_type, got.event_type);
            cmp("channel", want.channel, got.channel);
            cmp("param1", want.param1, got.param1);
            cmp("param2", want.param2, got.param2);
            cmp("meta_type", want.meta_type, got.meta_type);
            cmp("length", want.length, got.length);
            cmp("format", want.format, got.format);
            cmp("track_count", want.track_count, got.track_count);
            cmp("smpte_division", want.smpte_division, got.smpte_division);
            cmp("time_division", want.time_division, got.time_division);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        restart;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  kind;
    logic [31:0] delta;
    logic [7:0]  event_type;
    logic [3:0]  channel;
    logic [7:0]  param1;
    logic [7:0]  param2;
    logic [7:0]  meta_type;
    logic [31:0] length;
    logic [15:0] format;
    logic [15:0] track_count;
    logic        smpte_division;
    logic [14:0] time_division;

    result_t        seen;
    smf_event_board board = new();
    byte_req_t      byte_plan[$];
    logic [7:0]     gen_rs;
    int             files_made;
    int             requests_sent;
    int             hold_count;

    midi_file_stream_parser_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .restart        (restart),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .delta          (delta),
        .event_type     (event_type),
        .channel        (channel),
        .param1         (param1),
        .param2         (param2),
        .meta_type      (meta_type),
        .length         (length),
        .format         (format),
        .track_count    (track_count),
        .smpte_division (smpte_division),
        .time_division  (time_division)
    );

    // result fields packed in the same order as the package struct
    assign seen = {kind, delta, event_type, channel, param1, param2, meta_type, length,
                   format, track_count, smpte_division, time_division};

    initial
        clk = 1'b0;

    always #6 clk = ~clk;

    // ---------------------------------------------------------------
    // stimulus planning: byte streams are built up front in byte_plan
    // ---------------------------------------------------------------

    function automatic void plan_byte(logic [7:0] b);
        byte_plan.push_back({1'b0, b});
    endfunction

    // restart request, its data byte is don't-care for the parser
    function automatic void plan_restart(logic [7:0] b);
        byte_plan.push_back({1'b1, b});
    endfunction

    // a good byte that is now and then swapped for a random one
    function automatic logic [7:0] maybe_bad(logic [7:0] good, int odds);
        return ($urandom_range(1, odds) == 1) ? 8'($urandom) : good;
    endfunction

    // variable-length quantity, optionally with a redundant leading 0x80 group
    function automatic void plan_vlq(int unsigned v, bit pad);
        logic [7:0] grp[$];
        grp.push_front({1'b0, v[6:0]});
        v = v >> 7;
        while (v != 0)
        begin
            grp.push_front({1'b1, v[6:0]});
            v = v >> 7;
        end
        if (pad)
            grp.push_front(8'h80);
        foreach (grp[i])
            plan_byte(grp[i]);
    endfunction

    // deltas: mostly short, some multi-byte, and a few long enough to overflow 32 bits
    function automatic void plan_delta();
        int pick;
        int n;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            plan_byte(8'h00);
        else if (pick < 7)
            plan_vlq($urandom_range(1, 127), 1'b0);
        else if (pick < 9)
            plan_vlq($urandom_range(128, 2097151), $urandom_range(0, 3) == 0);
        else
        begin
            n = $urandom_range(5, 6);
            repeat (n - 1)
                plan_byte(8'($urandom_range(128, 255)));
            plan_byte(8'($urandom_range(0, 127)));
        end
    endfunction

    // channel data bytes, one for program change and channel pressure
    function automatic void plan_chan_data(logic [7:0] st);
        plan_byte(8'($urandom_range(0, 127)));
        if (st[7:4] != TYPE_PROG_CHANGE && st[7:4] != TYPE_CHAN_PRESS)
            plan_byte(8'($urandom_range(0, 127)));
    endfunction

    // meta or sysex length plus payload, zero length included
    function automatic void plan_payload();
        int n;
        n = $urandom_range(0, 5);
        plan_vlq(n, $urandom_range(0, 7) == 0);
        repeat (n)
            plan_byte(8'($urandom));
    endfunction

    // one event after its delta, returns 1 when it breaks the stream
    function automatic bit plan_event();
        int         pick;
        logic [7:0] st;
        plan_delta();
        pick = $urandom_range(0, 99);
        if (pick < 30 || (pick < 50 && gen_rs == 0))
        begin
            st     = 8'($urandom_range(8'h80, 8'hEF));
            gen_rs = st;
            plan_byte(st);
            plan_chan_data(st);
        end
        else if (pick < 50)
            plan_chan_data(gen_rs);       // running status
        else if (pick < 72)
        begin
            plan_byte(STATUS_META);
            do
                st = 8'($urandom);
            while (st == META_END_OF_TRACK);
            plan_byte(st);
            plan_payload();
        end
        else if (pick < 98)
        begin
            plan_byte(pick[0] ? STATUS_SYSEX : STATUS_SYSEX_ESC);
            plan_payload();
        end
        else
        begin
            // undefined system status
            st = 8'($urandom_range(8'hF1, 8'hFE));
            if (st == STATUS_SYSEX_ESC)
                st = 8'hFE;
            plan_byte(st);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit plan_track();
        int n;
        for (int i = 0; i < 4; i++)
            plan_byte(maybe_bad(TRK_MAGIC[i], 80));
        repeat (4)
            plan_byte(8'($urandom));      // chunk length is skipped
        gen_rs = 8'h00;
        // stray data byte before any status in this track
        if ($urandom_range(0, 39) == 0)
        begin
            plan_delta();
            plan_byte(8'($urandom_range(0, 127)));
            return 1'b1;
        end
        n = $urandom_range(1, 8);
        repeat (n)
            if (plan_event())
                return 1'b1;
        plan_delta();
        plan_byte(STATUS_META);
        plan_byte(META_END_OF_TRACK);
        if ($urandom_range(0, 5) == 0)
        begin
            plan_vlq(1, 1'b0);
            plan_byte(8'($urandom));
        end
        else
            plan_byte(8'h00);
        return 1'b0;
    endfunction

    // a whole file: restart, header, a few tracks, then, for a small track count, up to three trailing bytes
    function automatic void plan_file();
        int          pick;
        int          made;
        logic [15:0] fmt;
        logic [15:0] ntrk;
        logic [15:0] div;
        plan_restart(8'($urandom));
        files_made++;
        for (int i = 0; i < 4; i++)
            plan_byte(maybe_bad(HDR_MAGIC[i], 60));
        repeat (3)
            plan_byte(8'h00);
        plan_byte(maybe_bad(HDR_LENGTH[7:0], 30));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            ntrk = 16'd0;
        else if (pick == 1)
            ntrk = 16'($urandom_range(4, 65535));
        else
            ntrk = 16'($urandom_range(1, 3));
        fmt = 16'($urandom);
        div = 16'($urandom);
        plan_byte(fmt[15:8]);
        plan_byte(fmt[7:0]);
        plan_byte(ntrk[15:8]);
        plan_byte(ntrk[7:0]);
        plan_byte(div[15:8]);
        plan_byte(div[7:0]);
        // a large track count is cut short by the next restart
        made = (ntrk > 3) ? $urandom_range(1, 3) : ntrk;
        for (int t = 0; t < made; t++)
            if (plan_track())
                return;
        if (ntrk <= 3)
            repeat ($urandom_range(0, 3))
                plan_byte(8'($urandom));
    endfunction

    // ---------------------------------------------------------------
    // byte channel driver
    // ---------------------------------------------------------------

    // offer one request at the falling edge, hold it until accepted
    task automatic send_req(byte_req_t q);
        @(negedge clk);
        in_valid <= 1'b1;
        restart  <= q.rs;
        in_byte  <= q.b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(q.rs, q.b);
        requests_sent++;
    endtask

    // idle cycles with junk on the data lines
    task automatic idle(int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            restart  <= 1'($urandom);
            in_byte  <= 8'($urandom);
        end
    endtask

    // bursts of random length with random gaps, sometimes back to back
    task automatic send_plan();
        int k;
        int burst;
        k = 0;
        while (k < byte_plan.size())
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && k < byte_plan.size())
            begin
                send_req(byte_plan[k]);
                k++;
                burst--;
            end
            if ($urandom_range(0, 3) != 0)
                idle($urandom_range(1, 8));
        end
        byte_plan.delete();
    endtask

    // stop offering and wait for every awaited result
    task automatic wait_drained();
        idle(1);
        while (board.awaited_events.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // result channel: stall pattern and monitor
    // ---------------------------------------------------------------

    // stall in segments: free running, random, a bit pattern, or a long hold
    initial
    begin
        int          seg;
        int          span;
        int          mode;
        logic [31:0] pat;
        out_stall  = 1'b0;
        hold_count = 0;
        seg        = 0;
        wait (rst_n);
        forever
        begin
            seg++;
            span = $urandom_range(10, 120);
            mode = $urandom_range(0, 2);
            pat  = $urandom;
            // long hold so the output register fills and the input backs up
            if (seg % 9 == 3)
            begin
                mode = 3;
                span = 250;
                hold_count++;
            end
            for (int i = 0; i < span; i++)
            begin
                @(negedge clk);
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= pat[i % 32];
                    default: out_stall <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_event(seen);
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        restart       = 1'b0;
        in_byte       = 8'h00;
        files_made    = 0;
        requests_sent = 0;
        gen_rs        = 8'h00;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // bad magic on a zero byte, then a byte dropped while the error is latched
        plan_restart(8'h5A);
        for (int i = 0; i < 3; i++)
            plan_byte(HDR_MAGIC[i]);
        plan_byte(8'h00);
        plan_byte(8'hFF);
        // header length of all ones
        plan_restart(8'hFF);
        for (int i = 0; i < 4; i++)
            plan_byte(HDR_MAGIC[i]);
        repeat (4)
            plan_byte(8'hFF);
        // good header start, cut off by the restart of the first random file
        plan_restart(8'h00);
        for (int i = 0; i < 4; i++)
            plan_byte(HDR_MAGIC[i]);
        repeat (3)
            plan_byte(8'h00);
        plan_byte(HDR_LENGTH[7:0]);
        send_plan();
        wait_drained();

        // random files, mostly well formed with occasional breakage
        while (byte_plan.size() < 1100)
            plan_file();
        send_plan();
        wait_drained();
        repeat (20)
            @(posedge clk);

        $display("run sent %0d requests over %0d random files with %0d long result holds",
                 requests_sent, files_made, hold_count);
        $display("results seen: header %0d, channel %0d, meta %0d + %0d data, sysex %0d, error %0d",
                 board.kind_seen[KIND_HEADER], board.kind_seen[KIND_CHANNEL],
                 board.kind_seen[KIND_META_HDR], board.kind_seen[KIND_META_DATA],
                 board.kind_seen[KIND_SYSEX], board.kind_seen[KIND_ERROR]);
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial
    begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mfsp_pkg.sv
rtl/core/midi_file_stream_parser_core.sv
sim/tb.sv
